// ===== rtl/bpfc_pkg.sv =====
// Shared types, codes and the Bayer table of the blit pixel format converter.
package bpfc_pkg;

  // Fixed field widths.
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned FMT_W   = 3;
  localparam int unsigned CADDR_W = 1;
  localparam int unsigned CDATA_W = 3;

  // Dither matrix geometry.
  localparam int unsigned DITHER_SIZE = 8;
  localparam int unsigned DIDX_W      = $clog2(DITHER_SIZE);
  localparam int unsigned DVAL_W      = 2 * DIDX_W;

  // Destination format codes.
  localparam logic [FMT_W-1:0] FMT_TEXTURE = 3'd0;
  localparam logic [FMT_W-1:0] FMT_SCR32   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_SCR24   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_SCR565  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_SCR555  = 3'd4;

  // Configuration register indexes.
  localparam logic [CADDR_W-1:0] REG_DEST_FORMAT  = 1'd0;
  localparam logic [CADDR_W-1:0] REG_BLEND_ENABLE = 1'd1;

  // Byte counts of the stored word.
  localparam logic [CNT_W-1:0] CNT_32 = 3'd4;
  localparam logic [CNT_W-1:0] CNT_24 = 3'd3;
  localparam logic [CNT_W-1:0] CNT_16 = 3'd2;

  // Saturation limits of the packed channels.
  localparam logic [6:0] LIM5 = 7'd31;
  localparam logic [6:0] LIM6 = 7'd63;

  // Register settings seen by the datapath.
  typedef struct packed {
    logic [FMT_W-1:0] dest_format;
    logic             blend_enable;
  } cfg_t;

  // One input item; the source pixel sits in the lowest bits.
  typedef struct packed {
    logic [POS_W-1:0] y_pos;
    logic [POS_W-1:0] x_pos;
    logic [PIX_W-1:0] dst_pixel;
    logic [PIX_W-1:0] src_pixel;
  } pix_in_t;

  // One result item, padded to whole bytes.
  typedef struct packed {
    logic [3:0]       pad;
    logic             write_enable;
    logic [CNT_W-1:0] byte_count;
    logic [PIX_W-1:0] out_pixel;
  } pix_out_t;

  // 8x8 ordered dither threshold, row-major, row 5 column 6 holds 45.
  function automatic logic [DVAL_W-1:0] bayer(input logic [DIDX_W-1:0] row,
                                              input logic [DIDX_W-1:0] col);
    logic [DVAL_W-1:0] tab [DITHER_SIZE*DITHER_SIZE];
    tab = '{
      6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
      6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
      6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
      6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
      6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
      6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
      6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
      6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
    };
    return tab[{row, col}];
  endfunction

endpackage

// ===== rtl/bpfc_blend.sv =====
// Alpha blend of channels 0..2 of the source over the destination pixel.
module bpfc_blend (
  input  logic [bpfc_pkg::PIX_W-1:0] src_pixel,
  input  logic [bpfc_pkg::PIX_W-1:0] dst_pixel,
  output logic [bpfc_pkg::PIX_W-1:0] blend_pixel
);

  logic [7:0] alpha;
  logic [7:0] alpha_cpl;
  logic [7:0] chan [3];

  assign alpha     = src_pixel[31:24];
  assign alpha_cpl = 8'd255 - alpha;

  // Each channel is a*s + (255-a)*d; the sum stays below 2^16.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [15:0] prod_s;
      logic [15:0] prod_d;
      logic [15:0] sum;
      prod_s  = 16'(alpha) * 16'(src_pixel[8*i +: 8]);
      prod_d  = 16'(alpha_cpl) * 16'(dst_pixel[8*i +: 8]);
      sum     = prod_s + prod_d;
      chan[i] = sum[15:8];
    end
  end

  // Alpha byte of the destination is kept.
  assign blend_pixel = {dst_pixel[31:24], chan[2], chan[1], chan[0]};

endmodule

// ===== rtl/bpfc_dither.sv =====
// Ordered dithering and saturating pack into 5:6:5 and 5:5:5 words.
module bpfc_dither (
  input  logic [bpfc_pkg::PIX_W-1:0] src_pixel,
  input  logic [bpfc_pkg::POS_W-1:0] x_pos,
  input  logic [bpfc_pkg::POS_W-1:0] y_pos,
  output logic [15:0]                pix565,
  output logic [15:0]                pix555
);

  logic [bpfc_pkg::DVAL_W-1:0] thr;
  logic [4:0] r5;
  logic [4:0] g5;
  logic [5:0] g6;
  logic [4:0] b5;

  // Add a scaled threshold, shift down and clamp to the channel limit.
  function automatic logic [6:0] sat_shift(input logic [7:0] c,
                                           input logic [3:0] add,
                                           input logic       six_bit);
    logic [8:0] sum;
    logic [6:0] v;
    sum = {1'b0, c} + {5'd0, add};
    if (six_bit) begin
      v = sum[8:2];
      return (v > bpfc_pkg::LIM6) ? bpfc_pkg::LIM6 : v;
    end
    v = {1'b0, sum[8:3]};
    return (v > bpfc_pkg::LIM5) ? bpfc_pkg::LIM5 : v;
  endfunction

  assign thr = bpfc_pkg::bayer(y_pos[bpfc_pkg::DIDX_W-1:0], x_pos[bpfc_pkg::DIDX_W-1:0]);

  // Threshold divided by 8 for 5-bit channels and by 4 for the 6-bit one.
  always_comb begin
    logic [6:0] t0;
    logic [6:0] t1;
    logic [6:0] t2;
    logic [6:0] t3;
    t0 = sat_shift(src_pixel[7:0],   {1'b0, thr[5:3]}, 1'b0);
    t1 = sat_shift(src_pixel[15:8],  {1'b0, thr[5:3]}, 1'b0);
    t2 = sat_shift(src_pixel[15:8],  thr[5:2],         1'b1);
    t3 = sat_shift(src_pixel[23:16], {1'b0, thr[5:3]}, 1'b0);
    b5 = t0[4:0];
    g5 = t1[4:0];
    g6 = t2[5:0];
    r5 = t3[4:0];
  end

  assign pix565 = {r5, g6, b5};
  assign pix555 = {1'b0, r5, g5, b5};

endmodule

// ===== rtl/bpfc_convert.sv =====
// Format selection: picks the destination word, byte count and write flag.
module bpfc_convert (
  input  bpfc_pkg::cfg_t     cfg,
  input  bpfc_pkg::pix_in_t  item,
  output bpfc_pkg::pix_out_t result
);

  logic [bpfc_pkg::PIX_W-1:0] blend_pixel;
  logic [15:0]                pix565;
  logic [15:0]                pix555;
  logic [7:0]                 alpha;

  bpfc_blend u_blend (
    .src_pixel   (item.src_pixel),
    .dst_pixel   (item.dst_pixel),
    .blend_pixel (blend_pixel)
  );

  bpfc_dither u_dither (
    .src_pixel (item.src_pixel),
    .x_pos     (item.x_pos),
    .y_pos     (item.y_pos),
    .pix565    (pix565),
    .pix555    (pix555)
  );

  assign alpha = item.src_pixel[31:24];

  // Output word per destination format.
  always_comb begin
    result              = '0;
    result.byte_count   = bpfc_pkg::CNT_32;
    result.write_enable = 1'b1;
    unique case (cfg.dest_format)
      bpfc_pkg::FMT_TEXTURE: begin
        if (!cfg.blend_enable || alpha == 8'hFF) begin
          result.out_pixel = item.src_pixel;
        end else if (alpha != 8'h00) begin
          result.out_pixel = blend_pixel;
        end else begin
          // Fully transparent source leaves the destination alone.
          result.out_pixel    = item.dst_pixel;
          result.write_enable = 1'b0;
        end
      end
      bpfc_pkg::FMT_SCR32: begin
        result.out_pixel = {item.src_pixel[23:0], item.src_pixel[31:24]};
      end
      bpfc_pkg::FMT_SCR24: begin
        result.out_pixel  = {8'd0, item.src_pixel[23:0]};
        result.byte_count = bpfc_pkg::CNT_24;
      end
      bpfc_pkg::FMT_SCR565: begin
        result.out_pixel  = {16'd0, pix565};
        result.byte_count = bpfc_pkg::CNT_16;
      end
      bpfc_pkg::FMT_SCR555: begin
        result.out_pixel  = {16'd0, pix555};
        result.byte_count = bpfc_pkg::CNT_16;
      end
      default: begin
        // Unassigned format codes store nothing.
        result.write_enable = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/blit_pixel_format_converter.sv =====
// Top level: registers, handshake and the input and result stages.
//
//   channel  direction  handshake                 payload
//   in_      slave      in_tvalid / in_tready     in_tdata (88 bits)
//   out_     master     out_tvalid / out_tready   out_tdata (40 bits)
//   cfg_     slave      cfg_valid / cfg_ready     cfg_addr, cfg_data
//
// An accepted item is held in the input register and moves into the result register
// once that register is empty or being drained; out_tvalid then rises, and the
// item leaves when out_tready is high.
// One item is accepted every cycle while out_tready is high; the single conversion stage sets the rate.
// A stalled output holds its result and the input register may still fill;
// back-pressure reaches in_tready only when both stages are full.
// Reset (rst_n low, synchronous) empties both stages and clears the
// configuration registers.
module blit_pixel_format_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Fields from bit 0: src_pixel[31:0], dst_pixel[63:32], x_pos[75:64],
  // y_pos[87:76].
  input  logic [87:0]                   in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: out_pixel[31:0], byte_count[34:32],
  // write_enable[35], zero[39:36].
  output logic [39:0]                   out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpfc_pkg::CADDR_W-1:0]  cfg_addr,
  input  logic [bpfc_pkg::CDATA_W-1:0]  cfg_data
);

  bpfc_pkg::cfg_t     cfg_r;
  bpfc_pkg::pix_in_t  in_r;
  logic               in_vld_r;
  bpfc_pkg::pix_out_t res_nxt;
  bpfc_pkg::pix_out_t res_r;
  logic               res_vld_r;
  logic               res_load;
  logic               in_acc;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_format  <= bpfc_pkg::FMT_TEXTURE;
      cfg_r.blend_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        bpfc_pkg::REG_DEST_FORMAT:  cfg_r.dest_format  <= cfg_data;
        bpfc_pkg::REG_BLEND_ENABLE: cfg_r.blend_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage flow: the result register loads when it is empty or being drained.
  assign res_load  = !res_vld_r || out_tready;
  assign in_tready = !in_vld_r || res_load;
  assign in_acc    = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= bpfc_pkg::pix_in_t'(in_tdata);
    end
  end

  bpfc_convert u_convert (
    .cfg    (cfg_r),
    .item   (in_r),
    .result (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_load) begin
      res_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = res_r;

  // An accepted item occupies the input register in the next cycle.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_vld_r)
    else $error("accepted item did not reach the input register");

  // A full input register moves on whenever the result register frees up.
  a_in_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && res_load |=> res_vld_r)
    else $error("input register did not advance into the result stage");

  // Two-byte results never carry bits above the low half-word.
  a_short_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.byte_count == bpfc_pkg::CNT_16 |-> res_r.out_pixel[31:16] == 16'd0)
    else $error("16-bit result has high bits set");

endmodule
